[sv/swdh_pkg.sv]
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types and constants for the SWD host debug-port transaction engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

   // High clocks in each line-reset segment of a select
   localparam int RESET_CLOCKS = 52;

   // Item kind carried on tuser
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_CLOCK = 1'b1;

   // Operations
   localparam logic [1:0] OP_SELECT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_WRITE  = 2'd2;

   // Completion status
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ACK_FAULT  = 2'd1;
   localparam logic [1:0] ST_PARITY_ERR = 2'd2;

   // Select segments, kept in the low bits of the data shifter
   localparam logic [1:0] SEG_RESET_A = 2'd0;
   localparam logic [1:0] SEG_SWITCH  = 2'd1;
   localparam logic [1:0] SEG_RESET_B = 2'd2;
   localparam logic [1:0] SEG_IDLE    = 2'd3;

   // Expected ACK (OK), first sampled bit in bit 0
   localparam logic [2:0] ACK_OK = 3'b001;

   // Switch sequence, bit i is sent on clock i of the switch segment
   localparam logic [15:0] SWITCH_SEQ = 16'b1110_0111_1001_1110;

   // Clock index landmarks of a DP read or write
   localparam logic [7:0] CI_REQ_LAST   = 8'd7;
   localparam logic [7:0] CI_ACK_FIRST  = 8'd9;
   localparam logic [7:0] CI_ACK_MID    = 8'd10;
   localparam logic [7:0] CI_ACK_LAST   = 8'd11;
   localparam logic [7:0] CI_RD_DATA_END = 8'd43;
   localparam logic [7:0] CI_RD_PARITY  = 8'd44;
   localparam logic [7:0] CI_RD_DONE    = 8'd48;
   localparam logic [7:0] CI_WR_TURN    = 8'd12;
   localparam logic [7:0] CI_WR_DATA_END = 8'd44;
   localparam logic [7:0] CI_WR_PARITY  = 8'd45;
   localparam logic [7:0] CI_WR_DONE    = 8'd47;

   typedef struct packed {
      logic        busy;
      logic [1:0]  op;
      logic [7:0]  clock_index;
      logic [31:0] data_shift;
      logic        parity;
      logic [2:0]  ack;
      logic [1:0]  addr;
   } engine_state_type;

   typedef struct packed {
      logic        mode;
      logic [1:0]  operation;
      logic [3:0]  byte_address;
      logic [31:0] write_data;
      logic        line_sample;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  ack_code;
      logic [1:0]  status;
      logic        line_drive;
      logic        line_out;
      logic        clock_pulse;
   } rsp_payload_type;

endpackage

[sv/swdh_step.sv]
// ----------------------------------------------------------------------------
// swdh_step
// Next-state and result logic for one SWCLK period or start transaction.
// ----------------------------------------------------------------------------
module swdh_step import swdh_pkg::*; (
   input  engine_state_type cur_state,
   input  req_item_type     item,
   output engine_state_type nxt_state,
   output rsp_payload_type  result,
   output logic             done_res
);

   logic [1:0] seg;
   logic [8:0] seg_len;
   logic [8:0] ci_inc;
   logic [7:0] ci;
   logic       is_read;
   logic       a2;
   logic       a3;
   logic       s;
   logic       lo;

   assign ci      = cur_state.clock_index;
   assign ci_inc  = {1'b0, ci} + 9'd1;
   assign seg     = cur_state.data_shift[1:0];
   assign is_read = (cur_state.op == OP_READ);
   assign a2      = cur_state.addr[0];
   assign a3      = cur_state.addr[1];
   assign s       = item.line_sample;

   always_comb begin
      nxt_state          = cur_state;
      result             = '0;
      result.line_drive  = 1'b1;
      done_res           = 1'b0;
      lo                 = 1'b0;
      seg_len            = 9'(RESET_CLOCKS);

      if (item.mode == MODE_START) begin
         if (!cur_state.busy && (item.operation != 2'd3)) begin
            nxt_state.busy        = 1'b1;
            nxt_state.op          = item.operation;
            nxt_state.clock_index = '0;
            nxt_state.data_shift  = (item.operation == OP_WRITE) ? item.write_data : '0;
            nxt_state.parity      = 1'b0;
            nxt_state.ack         = '0;
            nxt_state.addr        = item.byte_address[3:2];
         end
      end else if (cur_state.busy) begin
         result.clock_pulse = 1'b1;
         if (cur_state.op == OP_SELECT) begin
            unique case (seg)
               SEG_SWITCH: begin
                  seg_len = 9'd16;
                  lo      = SWITCH_SEQ[ci[3:0]];
               end
               SEG_IDLE: begin
                  seg_len = 9'd8;
                  lo      = 1'b0;
               end
               default: begin
                  seg_len = 9'(RESET_CLOCKS);
                  lo      = 1'b1;
               end
            endcase
            if (ci_inc >= seg_len) begin
               nxt_state.clock_index = '0;
               if (seg == SEG_IDLE) begin
                  done_res             = 1'b1;
                  nxt_state.busy       = 1'b0;
                  nxt_state.data_shift = '0;
               end else begin
                  nxt_state.data_shift = {30'd0, seg + 2'd1};
               end
            end else begin
               nxt_state.clock_index = ci_inc[7:0];
            end
         end else begin
            nxt_state.clock_index = ci_inc[7:0];
            if (ci <= CI_REQ_LAST) begin
               // request header: start, APnDP, RnW, A2, A3, parity, stop, park
               unique case (ci[2:0])
                  3'd0:    lo = 1'b1;
                  3'd1:    lo = 1'b0;
                  3'd2:    lo = is_read;
                  3'd3:    lo = a2;
                  3'd4:    lo = a3;
                  3'd5:    lo = a2 ^ a3 ^ is_read;
                  3'd6:    lo = 1'b0;
                  default: lo = 1'b1;
               endcase
            end else if (ci <= CI_ACK_LAST) begin
               // turnaround, then three ACK bits
               result.line_drive = 1'b0;
               lo                = 1'b1;
               if (ci == CI_ACK_FIRST) nxt_state.ack[0] = cur_state.ack[0] | s;
               if (ci == CI_ACK_MID)   nxt_state.ack[1] = cur_state.ack[1] | s;
               if (ci == CI_ACK_LAST) begin
                  nxt_state.ack[2] = cur_state.ack[2] | s;
                  if (nxt_state.ack != ACK_OK) begin
                     done_res       = 1'b1;
                     result.status  = ST_ACK_FAULT;
                     nxt_state.busy = 1'b0;
                  end
               end
            end else if (is_read) begin
               if (ci <= CI_RD_DATA_END) begin
                  result.line_drive    = 1'b0;
                  lo                   = 1'b1;
                  nxt_state.data_shift = {s, cur_state.data_shift[31:1]};
                  nxt_state.parity     = cur_state.parity ^ s;
               end else if (ci == CI_RD_PARITY) begin
                  result.line_drive = 1'b0;
                  lo                = 1'b1;
                  if (s != cur_state.parity) begin
                     done_res       = 1'b1;
                     result.status  = ST_PARITY_ERR;
                     nxt_state.busy = 1'b0;
                  end
               end else begin
                  lo = 1'b0;
                  if (ci >= CI_RD_DONE) begin
                     done_res         = 1'b1;
                     nxt_state.busy   = 1'b0;
                     result.read_data = cur_state.data_shift;
                  end
               end
            end else begin
               if (ci == CI_WR_TURN) begin
                  result.line_drive = 1'b0;
                  lo                = 1'b1;
               end else if (ci <= CI_WR_DATA_END) begin
                  lo                   = cur_state.data_shift[0];
                  nxt_state.parity     = cur_state.parity ^ cur_state.data_shift[0];
                  nxt_state.data_shift = {1'b0, cur_state.data_shift[31:1]};
               end else if (ci == CI_WR_PARITY) begin
                  lo = cur_state.parity;
               end else begin
                  lo = 1'b0;
                  if (ci >= CI_WR_DONE) begin
                     done_res       = 1'b1;
                     nxt_state.busy = 1'b0;
                  end
               end
            end
         end
      end

      result.line_out = lo;
      result.ack_code = nxt_state.ack;
   end

endmodule

[sv/swd_host_dp_transaction.sv]
// ----------------------------------------------------------------------------
// swd_host_dp_transaction
// SWD host engine: line reset and select, DP register read and DP write.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              Content
//  req_     in   req_tvalid/req_tready  start or one SWCLK period with sample
//  rsp_     out  rsp_tvalid/rsp_tready  SWCLK/SWDIO control, status, read data
//
//  Every accepted transaction yields exactly one response, registered and shown in the next cycle.
//  A new request is accepted each cycle while the response register is empty
//  or being drained, so the sustained rate is one transaction per clock; the
//  only stall source is rsp_tready low with a response held.
//  Reset clears the engine state and the response valid flag; the engine
//  starts idle.
//
module swd_host_dp_transaction import swdh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // operation[1:0], byte_address[5:2],
                                   // write_data[37:6], line_sample[38], zero[39]
   input  logic        req_tuser,  // mode[0]: 0 start, 1 clock period
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // clock_pulse[0], line_out[1], line_drive[2],
                                   // status[4:3], ack_code[7:5], read_data[39:8]
   output logic        rsp_tlast   // done_res: final clock of a transaction
);

   engine_state_type state_ff;
   engine_state_type state_in;
   req_item_type     item;
   rsp_payload_type  result;
   logic             done_res;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_data_ff;
   logic             rsp_last_ff;
   logic             req_accept;

   // Unpack the request transaction
   assign item.mode         = req_tuser;
   assign item.operation    = req_tdata[1:0];
   assign item.byte_address = req_tdata[5:2];
   assign item.write_data   = req_tdata[37:6];
   assign item.line_sample  = req_tdata[38];

   swdh_step u_step (
      .cur_state (state_ff),
      .item      (item),
      .nxt_state (state_in),
      .result    (result),
      .done_res  (done_res)
   );

   // Take a new request whenever the response slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Advance the engine only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // Response payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
         rsp_last_ff <= done_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Non-OK status only appears on the closing clock
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_data_ff.status != ST_OK) |-> rsp_tlast)
      else $error("status reported without transaction end");

   // Closing clock always issues an SWCLK pulse
   a_done_has_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_data_ff.clock_pulse)
      else $error("transaction end without SWCLK");

   // Read data is only shown on a clean completion
   a_read_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_data_ff.read_data != '0) |->
         rsp_tlast && (rsp_data_ff.status == ST_OK))
      else $error("read data outside a clean completion");

   // Idle engine issues no clock
   a_idle_no_clock: assert property (@(posedge clock) disable iff (reset)
      req_accept && !state_ff.busy |=> !rsp_data_ff.clock_pulse && !rsp_tlast)
      else $error("clock issued while idle");

   // Released line reads as pull-up level
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data_ff.line_drive |-> rsp_data_ff.line_out)
      else $error("released line not at pull-up level");

endmodule
